FILE: hdl/rational_arith_unit_macros.svh
// assertion macros for the rational arithmetic unit checker
// no dependencies; included by the checker file only
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define RAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rau check failed");

// next-cycle implication, quiet during reset
`define RAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rau check failed");

`endif

FILE: hdl/rau_pkg.sv
// shared types and codes for the rational arithmetic unit
// no dependencies
`timescale 1ns / 1ps

package rau_pkg;

  localparam int PORT_W = 32;
  localparam int WIDE_W = 64;
  localparam int DEN_W  = 62;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_CMP = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
  localparam logic [1:0] ST_DEN_FIXED = 2'd2;

  localparam logic [WIDE_W-1:0] NUMER_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic [WIDE_W-1:0] DENOM_MAX = {{(WIDE_W-DEN_W){1'b0}}, {DEN_W{1'b1}}};

  // divider handshake between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: hdl/rau_if.sv
// request and response channel interfaces
// depends on rau_pkg
`timescale 1ns / 1ps

interface rau_req_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         action;
  logic signed [rau_pkg::PORT_W-1:0]  a_numer;
  logic signed [rau_pkg::PORT_W-1:0]  a_denom;
  logic signed [rau_pkg::PORT_W-1:0]  b_numer;
  logic signed [rau_pkg::PORT_W-1:0]  b_denom;
  modport source (output valid, action, a_numer, a_denom, b_numer, b_denom, input ready);
  modport sink   (input valid, action, a_numer, a_denom, b_numer, b_denom, output ready);
endinterface

interface rau_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [rau_pkg::WIDE_W-1:0]  res_numer;
  logic [rau_pkg::DEN_W-1:0]          res_denom;
  logic                               is_equal;
  logic [1:0]                         status;
  modport source (output valid, res_numer, res_denom, is_equal, status, input ready);
  modport sink   (input valid, res_numer, res_denom, is_equal, status, output ready);
endinterface

FILE: hdl/rau_div.sv
// 64-bit restoring divider, one quotient bit per cycle
// depends on rau_pkg
`timescale 1ns / 1ps

module rau_div (
  input  logic                         clk,
  input  logic                         rst,
  input  rau_pkg::div_ctl_t            ctl,
  input  logic [rau_pkg::WIDE_W-1:0]   dividend,
  input  logic [rau_pkg::WIDE_W-1:0]   divisor,
  output rau_pkg::div_sts_t            sts,
  output logic [rau_pkg::WIDE_W-1:0]   quotient
);

  localparam int W  = rau_pkg::WIDE_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [W:0]    shifted;
  logic [W:0]    trial;
  logic          fits;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, quo[W-1]};
    trial   = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= fits ? trial[W-1:0] : shifted[W-1:0];
        quo <= {quo[W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = quo;

endmodule

FILE: hdl/rational_arith_unit.sv
// top level: sequencer, shared multiplier, binary gcd loop and divider
// depends on rau_pkg, rau_if and rau_div
`timescale 1ns / 1ps

// Rational arithmetic unit. One request word carries two fractions and an
// action (add, subtract, multiply, divide, compare equal); one response word
// returns the reduced fraction with a positive denominator, the equality flag
// and a status code. Requests are taken one at a time: ready is high only
// while the sequencer is idle. Compare, unknown actions and division by a
// zero fraction skip all arithmetic. Arithmetic forms its cross products one
// at a time on the shared OPERAND_WIDTH x OPERAND_WIDTH multiplier, then the
// 64-bit add, the binary gcd loop (data dependent length) and two passes
// through the bit-serial divider; a zero numerator skips the reduction.
// A finished response sits in the output register while the next request
// is accepted.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input logic     clk,
  input logic     rst,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);

  localparam int PW = rau_pkg::PORT_W;
  localparam int W  = rau_pkg::WIDE_W;
  localparam int MW = OPERAND_WIDTH;
  localparam int SH = PW - OPERAND_WIDTH;
  localparam int KW = $clog2(W);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_COMB, S_GCD, S_DIVN_GO, S_DIVN_WAIT,
    S_DIVD_GO, S_DIVD_WAIT, S_FIN
  } state_t;

  state_t state;

  // operand capture
  logic signed [PW-1:0] an_s, ad_s, bn_s, bd_s, ad_f, bd_f;
  logic [MW-1:0]        an_m, ad_m, bn_m, bd_m;
  logic                 repl;

  always_comb begin
    an_s = $signed(req.a_numer << SH) >>> SH;
    ad_s = $signed(req.a_denom << SH) >>> SH;
    bn_s = $signed(req.b_numer << SH) >>> SH;
    bd_s = $signed(req.b_denom << SH) >>> SH;
    ad_f = (ad_s == '0) ? PW'(1) : ad_s;
    bd_f = (bd_s == '0) ? PW'(1) : bd_s;
    repl = (ad_s == '0) || (bd_s == '0);
    an_m = an_s[PW-1] ? MW'(-an_s) : MW'(an_s);
    ad_m = ad_f[PW-1] ? MW'(-ad_f) : MW'(ad_f);
    bn_m = bn_s[PW-1] ? MW'(-bn_s) : MW'(bn_s);
    bd_m = bd_f[PW-1] ? MW'(-bd_f) : MW'(bd_f);
  end

  logic [2:0]    act;
  logic [MW-1:0] xn_m, xd_m, yn_m, yd_m;
  logic          xn_n, xd_n, yn_n, yd_n;

  // shared multiplier operand selection
  logic [1:0]      mstep;
  logic [MW-1:0]   mul_a, mul_b;
  logic            mul_neg;
  logic [2*MW-1:0] product;

  always_comb begin
    unique case (mstep)
      2'd0: begin
        mul_a   = xn_m;
        mul_b   = (act == rau_pkg::ACT_MUL) ? yn_m : yd_m;
        mul_neg = xn_n ^ ((act == rau_pkg::ACT_MUL) ? yn_n : yd_n);
      end
      2'd1: begin
        mul_a   = xd_m;
        mul_b   = (act == rau_pkg::ACT_DIV) ? yn_m : yd_m;
        mul_neg = xd_n ^ ((act == rau_pkg::ACT_DIV) ? yn_n : yd_n);
      end
      default: begin
        mul_a   = yn_m;
        mul_b   = xd_m;
        mul_neg = yn_n ^ xd_n ^ (act == rau_pkg::ACT_SUB);
      end
    endcase
    product = mul_a * mul_b;
  end

  logic [W-1:0] p0, p1, p2;
  logic         p0_n, p1_n, p2_n;

  // signed-magnitude sum of the two cross products for add and subtract, else the first product
  logic [W-1:0] sum_m;
  logic         sum_n;

  always_comb begin
    if (act == rau_pkg::ACT_ADD || act == rau_pkg::ACT_SUB) begin
      if (p0_n == p2_n) begin
        sum_m = p0 + p2;
        sum_n = p0_n;
      end else if (p0 >= p2) begin
        sum_m = p0 - p2;
        sum_n = p0_n;
      end else begin
        sum_m = p2 - p0;
        sum_n = p2_n;
      end
    end else begin
      sum_m = p0;
      sum_n = p0_n;
    end
  end

  // reduction datapath
  logic [W-1:0]  num_m, den_m, ga, gb, nm;
  logic          num_n, den_n;
  logic [KW-1:0] gk;

  rau_pkg::div_ctl_t div_ctl;
  rau_pkg::div_sts_t div_sts;
  logic [W-1:0]      div_dividend, div_divisor, div_quo;

  assign div_ctl.start = (state == S_DIVN_GO) || (state == S_DIVD_GO);
  assign div_dividend  = (state == S_DIVN_GO) ? num_m : den_m;
  assign div_divisor   = gb << gk;

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  // final normalisation of the reduced fraction
  logic [W-1:0] fin_numer, fin_denom;
  always_comb begin
    fin_denom = (div_quo > rau_pkg::DENOM_MAX) ? rau_pkg::DENOM_MAX : div_quo;
    if (num_n ^ den_n) fin_numer = -nm;
    else               fin_numer = nm[W-1] ? rau_pkg::NUMER_MAX : nm;
  end

  // pending response
  logic [W-1:0]     r_numer;
  logic [W-1:0]     r_denom;
  logic             r_eq;
  logic [1:0]       r_st;
  logic             out_valid;
  logic [W-1:0]     o_numer;
  logic [rau_pkg::DEN_W-1:0] o_denom;
  logic             o_eq;
  logic [1:0]       o_st;

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.res_numer = o_numer;
  assign rsp.res_denom = o_denom;
  assign rsp.is_equal  = o_eq;
  assign rsp.status    = o_st;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mstep     <= '0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            act  <= req.action;
            xn_m <= an_m; xd_m <= ad_m; yn_m <= bn_m; yd_m <= bd_m;
            xn_n <= an_s[PW-1]; xd_n <= ad_f[PW-1];
            yn_n <= bn_s[PW-1]; yd_n <= bd_f[PW-1];
            mstep   <= '0;
            r_numer <= '0;
            r_denom <= W'(1);
            r_eq    <= (req.action == rau_pkg::ACT_CMP) && (an_s == bn_s) && (ad_f == bd_f);
            if (req.action > rau_pkg::ACT_CMP)
              r_st <= rau_pkg::ST_OK;
            else if (req.action == rau_pkg::ACT_DIV && bn_s == '0)
              r_st <= rau_pkg::ST_DIV_ZERO;
            else
              r_st <= repl ? rau_pkg::ST_DEN_FIXED : rau_pkg::ST_OK;
            if (req.action >= rau_pkg::ACT_CMP ||
                (req.action == rau_pkg::ACT_DIV && bn_s == '0))
              state <= S_FIN;
            else
              state <= S_MUL;
          end
        end
        S_MUL: begin
          mstep <= mstep + 1'b1;
          case (mstep)
            2'd0:    begin p0 <= W'(product); p0_n <= mul_neg; end
            2'd1:    begin p1 <= W'(product); p1_n <= mul_neg; end
            default: begin p2 <= W'(product); p2_n <= mul_neg; end
          endcase
          if (mstep == 2'd2 ||
              (mstep == 2'd1 && (act == rau_pkg::ACT_MUL || act == rau_pkg::ACT_DIV)))
            state <= S_COMB;
        end
        S_COMB: begin
          num_m <= sum_m;
          num_n <= sum_n;
          den_m <= p1;
          den_n <= p1_n;
          ga    <= sum_m;
          gb    <= p1;
          gk    <= '0;
          state <= (sum_m == '0) ? S_FIN : S_GCD;
        end
        S_GCD: begin
          if (ga == '0) begin
            state <= S_DIVN_GO;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + 1'b1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga >= gb) begin
            ga <= ga - gb;
          end else begin
            gb <= gb - ga;
          end
        end
        S_DIVN_GO: state <= S_DIVN_WAIT;
        S_DIVN_WAIT: begin
          if (div_sts.done) begin
            nm    <= div_quo;
            state <= S_DIVD_GO;
          end
        end
        S_DIVD_GO: state <= S_DIVD_WAIT;
        S_DIVD_WAIT: begin
          if (div_sts.done && !div_sts.busy) begin
            r_numer <= fin_numer;
            r_denom <= fin_denom;
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            o_numer   <= r_numer;
            o_denom   <= r_denom[rau_pkg::DEN_W-1:0];
            o_eq      <= r_eq;
            o_st      <= r_st;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/rau_checker.sv
// port-level checks for the rational arithmetic unit, bound to the top level
// depends on rau_pkg and rational_arith_unit_macros.svh
`timescale 1ns / 1ps
`include "rational_arith_unit_macros.svh"

module rau_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [rau_pkg::WIDE_W-1:0] res_numer,
  input logic [rau_pkg::DEN_W-1:0]         res_denom,
  input logic                              is_equal,
  input logic [1:0]                        status
);

  // one word at a time: no accept right after an accept
  `RAU_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

  // a waiting response word is held
  `RAU_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

  // denominator is never zero
  `RAU_ASSERT_NOW(a_denom_nonzero, rsp_valid, res_denom != '0)

  // division by a zero fraction gives zero over one
  `RAU_ASSERT_NOW(a_div_zero_result, rsp_valid && status == rau_pkg::ST_DIV_ZERO,
    res_numer == '0 && res_denom == rau_pkg::DEN_W'(1) && !is_equal)

  // an equal compare carries no fraction
  `RAU_ASSERT_NOW(a_equal_is_zero, rsp_valid && is_equal,
    res_numer == '0 && res_denom == rau_pkg::DEN_W'(1))

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .res_numer (rsp.res_numer),
  .res_denom (rsp.res_denom),
  .is_equal  (rsp.is_equal),
  .status    (rsp.status)
);
